>>> sv/assert_macros.svh
// Assertion macros shared by the edge filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of i_clk outside reset.
`define SCE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check that a condition is followed by a consequence in the next cycle.
`define SCE_ASSERT_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

>>> sv/sce_pkg.sv
// Constants, types and kernel arithmetic for the compass edge filter.
package sce_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int WID_W      = 11;
    localparam int HGT_W      = 13;
    localparam int CH_W       = 8;
    localparam int NCH        = 3;
    localparam int PIX_W      = NCH * CH_W;
    localparam int NTAP       = 9;
    localparam int NKERN      = 4;
    localparam int SUM_W      = 12;
    localparam int CFG_IDX_W  = 1;

    localparam logic [WID_W-1:0] WIDTH_RST  = WID_W'(640);
    localparam logic [HGT_W-1:0] HEIGHT_RST = HGT_W'(480);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

    // Input beat kinds carried on tuser
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef logic [NTAP-1:0]            t_mask;
    typedef logic [NTAP-1:0][CH_W-1:0]  t_taps;
    typedef logic [NTAP-1:0][PIX_W-1:0] t_win;

    // Four compass kernels; the other four are their negations.
    localparam int C_COMPASS [NKERN][NTAP] = '{
        '{-1,  0,  1,  -2,  0,  2,  -1,  0,  1},
        '{ 0,  1,  2,  -1,  0,  1,  -2, -1,  0},
        '{ 1,  2,  1,   0,  0,  0,  -1, -2, -1},
        '{ 2,  1,  0,   1,  0, -1,   0, -1, -2}
    };

    // Magnitude of one kernel response, saturated to a byte.
    function automatic logic [CH_W-1:0] kernel_mag(input int k, input t_taps v);
        logic signed [SUM_W-1:0] acc;
        logic signed [SUM_W-1:0] mag;
        acc = '0;
        for (int i = 0; i < NTAP; i++) begin
            acc = acc + SUM_W'(C_COMPASS[k][i]) * $signed(SUM_W'(v[i]));
        end
        mag = (acc < 0) ? -acc : acc;
        if (mag > SUM_W'(255)) begin
            return '1;
        end
        return mag[CH_W-1:0];
    endfunction

endpackage

>>> sv/sobel_compass_edge_filter_top.sv
// An output beat lags its pixel by one row plus one pixel. Accepted beats pass the stage-1,
// window, magnitude and output registers at one beat per cycle unless the output stalls.
// Line stores are two 1024 x 24 memories, both read at the column on a taken beat, one written.
// Reset (i_rst_n low, synchronous) empties the pipeline, zeroes the counters and window,
// and restores a 640 x 480 image; line memories keep their contents and need no clearing.
module sobel_compass_edge_filter_top
    import sce_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [PIX_W-1:0]     i_s_tdata,   // blue_in, green_in, red_in
    input  logic                 i_s_tuser,   // opcode
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [PIX_W-1:0]     o_m_tdata,   // blue_edge, green_edge, red_edge
    output logic                 o_m_tlast,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [HGT_W-1:0]     i_cfg_data
);

`include "assert_macros.svh"

    // Image geometry, stored already clamped
    logic [WID_W-1:0] r_w;
    logic [COL_W-1:0] r_wm1;
    logic [HGT_W-1:0] r_h;
    logic [ROW_W-1:0] r_hm1;

    logic [COL_W-1:0] r_in_col;
    logic [HGT_W-1:0] r_in_row;
    logic [COL_W-1:0] r_out_col;
    logic [ROW_W-1:0] r_out_row;

    logic [PIX_W-1:0] r_line_even [MAX_WIDTH];
    logic [PIX_W-1:0] r_line_odd  [MAX_WIDTH];
    logic [PIX_W-1:0] r_rd_even;
    logic [PIX_W-1:0] r_rd_odd;

    logic             r_v1, r_v2, r_v3, r_vo;
    logic [PIX_W-1:0] r_s1_pix;
    logic             r_s1_par, r_s1_emit, r_s1_fe;
    t_mask            r_s1_mask;
    t_win             r_win;
    logic             r_win_clr;
    logic             r_s2_emit, r_s2_fe;
    t_mask            r_s2_mask;
    logic [NCH-1:0][NKERN-1:0][CH_W-1:0] r_s3_mag;
    logic             r_s3_fe;
    logic [PIX_W-1:0] r_o_data;
    logic             r_o_last;

    logic             cfg_wr;
    logic [WID_W-1:0] n_w, cfg_wm1;
    logic [HGT_W-1:0] n_h, cfg_hm1;

    logic             ld4, s3_free, mv23, s2_free, mv12, s1_free;
    logic             acc, take, all_in, skip, drain, wrap, emit, fe;
    logic [COL_W-1:0] j;
    logic [WID_W-1:0] jp1;
    logic [2:0]       row_ok, col_ok;
    t_mask            mask;
    logic [PIX_W-1:0] top, mid;
    t_win             base, n_win;
    t_taps            taps [NCH];
    logic [NCH-1:0][NKERN-1:0][CH_W-1:0] mags;
    logic [PIX_W-1:0] n_o_data;
    logic [CH_W+1:0]  total;

    // Configuration write: clamp geometry to the supported range
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid;

    always_comb begin
        n_w = i_cfg_data[WID_W-1:0];
        if (n_w == '0) begin
            n_w = WID_W'(1);
        end else if (n_w > WID_W'(MAX_WIDTH)) begin
            n_w = WID_W'(MAX_WIDTH);
        end
        n_h = i_cfg_data;
        if (n_h == '0) begin
            n_h = HGT_W'(1);
        end else if (n_h > HGT_W'(MAX_HEIGHT)) begin
            n_h = HGT_W'(MAX_HEIGHT);
        end
        cfg_wm1 = n_w - WID_W'(1);
        cfg_hm1 = n_h - HGT_W'(1);
    end

    // Pipeline flow: a stage takes a beat when it is empty or its beat moves on
    assign ld4     = r_v3 && (!r_vo || i_m_tready);
    assign s3_free = !r_v3 || ld4;
    assign mv23    = r_v2 && s3_free;
    assign s2_free = !r_v2 || mv23;
    assign mv12    = r_v1 && s2_free;
    assign s1_free = !r_v1 || mv12;

    assign o_s_tready = s1_free;
    assign acc        = i_s_tvalid && s1_free;

    // Input stage decode from the raster counters
    always_comb begin
        all_in = r_in_row >= r_h;
        skip   = (i_s_tuser == OP_DRAIN) && !all_in;
        drain  = (i_s_tuser == OP_DRAIN) || all_in;
        take   = acc && !skip;
        j      = (r_in_col > r_wm1) ? r_wm1 : r_in_col;
        jp1    = WID_W'(j) + WID_W'(1);
        wrap   = jp1 >= r_w;
        emit   = (r_in_row >= HGT_W'(2)) || ((r_in_row == HGT_W'(1)) && (j != '0));
        fe     = (r_out_row == r_hm1) && (r_out_col == r_wm1);
        row_ok = {r_out_row != r_hm1, 1'b1, r_out_row != '0};
        col_ok = {r_out_col != r_wm1, 1'b1, r_out_col != '0};
        for (int fy = 0; fy < 3; fy++) begin
            for (int fx = 0; fx < 3; fx++) begin
                mask[fy*3+fx] = row_ok[fy] && col_ok[fx];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w       <= WIDTH_RST;
            r_wm1     <= COL_W'(WIDTH_RST - WID_W'(1));
            r_h       <= HEIGHT_RST;
            r_hm1     <= ROW_W'(HEIGHT_RST - HGT_W'(1));
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else if (cfg_wr) begin
            if (i_cfg_index == REG_WIDTH) begin
                r_w   <= n_w;
                r_wm1 <= cfg_wm1[COL_W-1:0];
            end else begin
                r_h   <= n_h;
                r_hm1 <= cfg_hm1[ROW_W-1:0];
            end
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else if (take) begin
            if (emit && fe) begin
                // last output of the frame: restart
                r_in_col  <= '0;
                r_in_row  <= '0;
                r_out_col <= '0;
                r_out_row <= '0;
            end else begin
                r_in_col <= wrap ? '0 : jp1[COL_W-1:0];
                if (wrap) begin
                    r_in_row <= r_in_row + HGT_W'(1);
                end
                if (emit) begin
                    if (r_out_col == r_wm1) begin
                        r_out_col <= '0;
                        r_out_row <= r_out_row + ROW_W'(1);
                    end else begin
                        r_out_col <= r_out_col + COL_W'(1);
                    end
                end
            end
        end
    end

    // Line stores: read both rows at the column, overwrite the older one
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_rd_even <= r_line_even[j];
            r_rd_odd  <= r_line_odd[j];
            if (!drain) begin
                if (r_in_row[0]) begin
                    r_line_odd[j] <= i_s_tdata;
                end else begin
                    r_line_even[j] <= i_s_tdata;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_s1_pix  <= drain ? '0 : i_s_tdata;
            r_s1_par  <= r_in_row[0];
            r_s1_emit <= emit;
            r_s1_fe   <= fe;
            r_s1_mask <= mask;
        end
    end

    // Window shift: new right column is older line, newer line, current pixel
    always_comb begin
        top   = r_s1_par ? r_rd_odd : r_rd_even;
        mid   = r_s1_par ? r_rd_even : r_rd_odd;
        base  = r_win_clr ? '0 : r_win;
        n_win = base;
        for (int fy = 0; fy < 3; fy++) begin
            n_win[fy*3]   = base[fy*3+1];
            n_win[fy*3+1] = base[fy*3+2];
        end
        n_win[2] = top;
        n_win[5] = mid;
        n_win[8] = r_s1_pix;
    end

    always_ff @(posedge i_clk) begin
        if (mv12) begin
            r_win     <= n_win;
            r_s2_emit <= r_s1_emit;
            r_s2_fe   <= r_s1_fe;
            r_s2_mask <= r_s1_mask;
        end
    end

    // Kernel responses on the masked window
    always_comb begin
        for (int ch = 0; ch < NCH; ch++) begin
            for (int i = 0; i < NTAP; i++) begin
                taps[ch][i] = r_s2_mask[i] ? r_win[i][ch*CH_W +: CH_W] : '0;
            end
            for (int k = 0; k < NKERN; k++) begin
                mags[ch][k] = kernel_mag(k, taps[ch]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mv23 && r_s2_emit) begin
            r_s3_mag <= mags;
            r_s3_fe  <= r_s2_fe;
        end
    end

    // Sum of four clamped responses divided by eight: each pair contributes one magnitude
    always_comb begin
        n_o_data = '0;
        total    = '0;
        for (int ch = 0; ch < NCH; ch++) begin
            total = '0;
            for (int k = 0; k < NKERN; k++) begin
                total = total + (CH_W+2)'(r_s3_mag[ch][k]);
            end
            n_o_data[ch*CH_W +: CH_W] = CH_W'(total[CH_W+1:3]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld4) begin
            r_o_data <= n_o_data;
            r_o_last <= r_s3_fe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
            r_vo      <= 1'b0;
            r_win_clr <= 1'b1;
        end else begin
            r_v1 <= take ? 1'b1 : (mv12 ? 1'b0 : r_v1);
            r_v2 <= mv12 ? 1'b1 : (mv23 ? 1'b0 : r_v2);
            r_v3 <= (mv23 && r_s2_emit) ? 1'b1 : (ld4 ? 1'b0 : r_v3);
            r_vo <= ld4 ? 1'b1 : (i_m_tready ? 1'b0 : r_vo);
            if (cfg_wr) begin
                r_win_clr <= 1'b1;
            end else if (mv12) begin
                // zero the window behind the frame's last output
                r_win_clr <= r_s1_emit && r_s1_fe;
            end
        end
    end

    assign o_m_tvalid = r_vo;
    assign o_m_tdata  = r_o_data;
    assign o_m_tlast  = r_o_last;

    `SCE_ASSERT(a_col_bounds, (r_in_col <= r_wm1) && (r_out_col <= r_wm1), "column out of range")
    `SCE_ASSERT(a_out_row_bound, r_out_row <= r_hm1, "output row past image")
    `SCE_ASSERT(a_in_row_bound,
        (HGT_W+1)'(r_in_row) <= (HGT_W+1)'(r_h) + (HGT_W+1)'(1), "input row overrun")
    `SCE_ASSERT_NEXT(a_frame_restart, take && emit && fe,
        (r_in_row == '0) && (r_out_row == '0) && (r_out_col == '0), "no restart after frame end")

endmodule

>>> sim/testbench.sv
// Self-checking testbench for the compass edge filter: stream stimulus, predictor, checker.
module testbench;
    import sce_pkg::*;

    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 6;
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_BEATS  = 420;
    localparam int RUN_LIMIT     = 5_000_000;

    // Four compass kernels, row major; the other four are their negations.
    localparam int KERN [4][9] = '{
        '{-1,  0,  1,  -2,  0,  2,  -1,  0,  1},
        '{ 0,  1,  2,  -1,  0,  1,  -2, -1,  0},
        '{ 1,  2,  1,   0,  0,  0,  -1, -2, -1},
        '{ 2,  1,  0,   1,  0, -1,   0, -1, -2}
    };

    typedef enum int {READY_ALWAYS, READY_RANDOM, READY_MOSTLY, READY_PERIODIC} t_ready_style;

    typedef struct packed {
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
        logic            frame_end;
    } t_edge_pixel;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_s_tvalid  = 1'b0;
    logic [PIX_W-1:0]     i_s_tdata   = '0;
    logic                 i_s_tuser   = OP_PIXEL;
    logic                 i_m_tready  = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = REG_WIDTH;
    logic [HGT_W-1:0]     i_cfg_data  = '0;
    logic                 o_s_tready;
    logic                 o_m_tvalid;
    logic [PIX_W-1:0]     o_m_tdata;
    logic                 o_m_tlast;
    logic                 o_cfg_ready;

    // Predictor state
    logic [WID_W-1:0] img_width  = WIDTH_RST;
    logic [HGT_W-1:0] img_height = HEIGHT_RST;
    logic [PIX_W-1:0] line_mem [2*MAX_WIDTH];
    logic [PIX_W-1:0] win [3][3];
    int unsigned      in_col, in_row_n, out_col, out_row_n;
    t_edge_pixel      pending_edges [$];

    int fail_count    = 0;
    int work_beats    = 0;
    int edges_checked = 0;
    int reg_writes    = 0;
    int frames_closed = 0;
    int burst_left    = 0;
    bit gaps_on       = 1'b1;

    t_ready_style stall_mode  = READY_RANDOM;
    logic         hold_toggle = 1'b0;
    logic         hold_seen   = 1'b0;
    int           hold_left   = 0;
    int unsigned  stall_tick  = 0;

    always #HALF_PERIOD i_clk = ~i_clk;

    sobel_compass_edge_filter_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    function automatic int unsigned eff_width();
        if (img_width == 0) return 1;
        if (img_width > MAX_WIDTH) return MAX_WIDTH;
        return img_width;
    endfunction

    function automatic int unsigned eff_height();
        if (img_height == 0) return 1;
        if (img_height > MAX_HEIGHT) return MAX_HEIGHT;
        return img_height;
    endfunction

    function automatic void restart_frame();
        int a;
        int b;
        for (a = 0; a < 3; a++) begin
            for (b = 0; b < 3; b++) begin
                win[a][b] = '0;
            end
        end
        in_col    = 0;
        in_row_n  = 0;
        out_col   = 0;
        out_row_n = 0;
    endfunction

    // Sum of the four clamped compass responses for one channel at the output, divided by eight.
    function automatic logic [CH_W-1:0] channel_edge(input int ch, input int unsigned w,
                                                     input int unsigned h);
        int tap [9];
        int s;
        int acc;
        int rr;
        int cc;
        int fy;
        int fx;
        int k;
        int i;
        acc = 0;
        for (fy = 0; fy < 3; fy++) begin
            for (fx = 0; fx < 3; fx++) begin
                rr = int'(out_row_n) + fy - 1;
                cc = int'(out_col) + fx - 1;
                if (rr >= 0 && rr < int'(h) && cc >= 0 && cc < int'(w)) begin
                    tap[fy*3+fx] = int'(win[fy][fx][ch*CH_W +: CH_W]);
                end else begin
                    tap[fy*3+fx] = 0;
                end
            end
        end
        for (k = 0; k < 4; k++) begin
            s = 0;
            for (i = 0; i < 9; i++) begin
                s += KERN[k][i] * tap[i];
            end
            if (s < 0) s = -s;
            if (s > 255) s = 255;
            acc += s;
        end
        return CH_W'(acc / 8);
    endfunction

    // Advance the filter by one accepted beat and queue the edge pixel it releases, if any.
    function automatic void predict_edge_step(input logic op, input logic [PIX_W-1:0] data);
        int unsigned w;
        int unsigned h;
        int unsigned r;
        int unsigned j;
        int unsigned top_idx;
        int unsigned mid_idx;
        logic        all_in;
        logic        drain;
        logic [PIX_W-1:0] pix;
        t_edge_pixel e;
        int a;
        w = eff_width();
        h = eff_height();
        all_in = (in_row_n >= h);
        // Drop a drain beat that arrives while pixels are still owed.
        if (op == OP_DRAIN && !all_in) return;
        work_beats++;
        drain = (op == OP_DRAIN) || all_in;
        pix = drain ? '0 : data;
        r = in_row_n;
        j = in_col;
        if (j >= w) j = w - 1;
        top_idx = (r % 2) * MAX_WIDTH + j;
        mid_idx = ((r + 1) % 2) * MAX_WIDTH + j;
        for (a = 0; a < 3; a++) begin
            win[a][0] = win[a][1];
            win[a][1] = win[a][2];
        end
        win[0][2] = line_mem[top_idx];
        win[1][2] = line_mem[mid_idx];
        win[2][2] = pix;
        if (!drain) line_mem[top_idx] = pix;
        in_col = j + 1;
        if (in_col >= w) begin
            in_col   = 0;
            in_row_n = r + 1;
        end
        if (r >= 2 || (r == 1 && j >= 1)) begin
            e.blue      = channel_edge(0, w, h);
            e.green     = channel_edge(1, w, h);
            e.red       = channel_edge(2, w, h);
            e.frame_end = (out_row_n == h - 1 && out_col == w - 1);
            pending_edges = {pending_edges, e};
            if (e.frame_end) begin
                restart_frame();
                frames_closed++;
            end else begin
                out_col++;
                if (out_col >= w) begin
                    out_col = 0;
                    out_row_n++;
                end
            end
        end
    endfunction

    function automatic logic [PIX_W-1:0] random_pixel();
        logic [PIX_W-1:0] p;
        int c;
        int style;
        p = PIX_W'($urandom());
        style = $urandom_range(0, 5);
        for (c = 0; c < NCH; c++) begin
            if (style == 0) begin
                p[c*CH_W +: CH_W] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end else if (style == 1) begin
                p[c*CH_W +: CH_W] = $urandom_range(0, 1) ? CH_W'($urandom_range(240, 255))
                                                         : CH_W'($urandom_range(0, 15));
            end
        end
        return p;
    endfunction

    task automatic send_beat(input logic op, input logic [PIX_W-1:0] data);
        int gap;
        if (burst_left == 0) begin
            gap = 0;
            if (gaps_on) begin
                gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 3);
            end
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= data;
        do @(posedge i_clk); while (!o_s_tready);
        predict_edge_step(op, data);
        burst_left--;
    endtask

    // Hold the input idle until every queued edge pixel is out, then let the pipe settle.
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_edges.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [HGT_W-1:0] val);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == REG_WIDTH) begin
            img_width = val[WID_W-1:0];
        end else begin
            img_height = val;
        end
        restart_frame();
        reg_writes++;
    endtask

    // Send pixels, with stray drain beats mixed in when noise is set.
    task automatic send_pixels(input int unsigned count, input bit noise);
        int unsigned n;
        for (n = 0; n < count; n++) begin
            if (noise && $urandom_range(0, 11) == 0) send_beat(OP_DRAIN, random_pixel());
            send_beat(OP_PIXEL, random_pixel());
        end
    endtask

    // Flush the tail of a frame; a pixel beat here counts as a drain.
    task automatic close_frame();
        int start;
        start = frames_closed;
        while (frames_closed == start) begin
            send_beat(($urandom_range(0, 2) == 0) ? OP_PIXEL : OP_DRAIN, random_pixel());
        end
    endtask

    task automatic run_frame(input bit noise);
        send_pixels(eff_width() * eff_height(), noise);
        close_frame();
    endtask

    task automatic test_default_geometry();
        // 640 x 480 out of reset: the first row is far from full, so nothing comes out
        // and stray drain beats are dropped.
        send_pixels(40, 1'b1);
    endtask

    task automatic test_directed_patterns();
        logic [PIX_W-1:0] pats [8];
        int i;
        pats = '{24'hFFFFFF, 24'h000000, 24'hFFFFFF, 24'h000000,
                 24'hFFFFFF, 24'h000000, 24'hAA55FF, 24'h55AA00};
        write_reg(REG_WIDTH, HGT_W'(3));
        write_reg(REG_HEIGHT, HGT_W'(3));
        for (i = 0; i < 8; i++) begin
            send_beat(OP_PIXEL, pats[i]);
        end
        // A drain before the last pixel is ignored.
        send_beat(OP_DRAIN, 24'h123456);
        send_beat(OP_PIXEL, 24'hFFFFFF);
        // A pixel past the end of the image acts as a drain.
        send_beat(OP_PIXEL, 24'hFFFFFF);
        close_frame();
        // Zero sizes clamp to a single pixel image.
        write_reg(REG_WIDTH, '0);
        write_reg(REG_HEIGHT, '0);
        send_beat(OP_PIXEL, 24'hFFFFFF);
        close_frame();
        send_beat(OP_DRAIN, 24'h000000);
    endtask

    task automatic test_size_extremes();
        // Oversized width clamps to the line store size; stay inside the first row.
        write_reg(REG_WIDTH, '1);
        write_reg(REG_HEIGHT, HGT_W'(1));
        send_pixels(24, 1'b1);
        // Oversized height on a one pixel wide image releases edge pixels early.
        write_reg(REG_WIDTH, HGT_W'(1));
        write_reg(REG_HEIGHT, '1);
        send_pixels(40, 1'b1);
        write_reg(REG_WIDTH, HGT_W'(MAX_WIDTH));
        write_reg(REG_HEIGHT, HGT_W'(MAX_HEIGHT));
        send_pixels(24, 1'b1);
    endtask

    task automatic test_backpressure();
        write_reg(REG_WIDTH, HGT_W'(6));
        write_reg(REG_HEIGHT, HGT_W'(6));
        stall_mode <= READY_ALWAYS;
        gaps_on = 1'b0;
        hold_toggle <= ~hold_toggle;
        run_frame(1'b0);
        gaps_on = 1'b1;
    endtask

    task automatic test_random_frames();
        int stop_at;
        int unsigned fw;
        int unsigned fh;
        bit aborted;
        stop_at = work_beats + RANDOM_BEATS;
        aborted = 1'b1;
        while (work_beats < stop_at) begin
            stall_mode <= t_ready_style'($urandom_range(0, 3));
            gaps_on = ($urandom_range(0, 3) != 0);
            if (aborted || $urandom_range(0, 3) != 0) begin
                fw = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 8);
                fh = $urandom_range(1, 6);
                if (fw == 1 && $urandom_range(0, 2) == 0) fw = 0;
                if (fh == 1 && $urandom_range(0, 2) == 0) fh = 0;
                if ($urandom_range(0, 1) == 0) begin
                    write_reg(REG_WIDTH, HGT_W'(fw));
                    write_reg(REG_HEIGHT, HGT_W'(fh));
                end else begin
                    write_reg(REG_HEIGHT, HGT_W'(fh));
                    write_reg(REG_WIDTH, HGT_W'(fw));
                end
                aborted = 1'b0;
            end
            if ($urandom_range(0, 11) == 0) begin
                // Cut the frame short; the next register write restarts it.
                send_pixels($urandom_range(0, eff_width() * eff_height() - 1), 1'b1);
                aborted = 1'b1;
            end else begin
                run_frame(1'b1);
            end
        end
    endtask

    // Receiver: stall pattern of its own, plus a long hold-off on request.
    always @(posedge i_clk) begin
        stall_tick <= stall_tick + 1;
        if (hold_toggle != hold_seen) begin
            hold_seen  <= hold_toggle;
            hold_left  <= HOLD_CYCLES;
            i_m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left  <= hold_left - 1;
            i_m_tready <= 1'b0;
        end else begin
            case (stall_mode)
                READY_ALWAYS:   i_m_tready <= 1'b1;
                READY_RANDOM:   i_m_tready <= 1'($urandom_range(0, 1));
                READY_MOSTLY:   i_m_tready <= ($urandom_range(0, 7) != 0);
                default:        i_m_tready <= ((stall_tick % 7) < 4);
            endcase
        end
    end

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_edge_pixel want_e;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_edges.size() == 0) begin
                $error("output beat with no edge pixel expected: tdata %h", o_m_tdata);
                fail_count++;
            end else begin
                want_e = pending_edges.pop_front();
                check_field("blue_edge", want_e.blue, o_m_tdata[0 +: CH_W]);
                check_field("green_edge", want_e.green, o_m_tdata[CH_W +: CH_W]);
                check_field("red_edge", want_e.red, o_m_tdata[2*CH_W +: CH_W]);
                check_field("frame_end", want_e.frame_end, o_m_tlast);
            end
            edges_checked++;
        end
    end

    initial begin
        #(RUN_LIMIT);
        $display("sobel_compass_edge_filter_top regression: fail");
        $finish;
    end

    initial begin
        int idx;
        for (idx = 0; idx < 2 * MAX_WIDTH; idx++) begin
            line_mem[idx] = '0;
        end
        restart_frame();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_geometry();
        test_directed_patterns();
        test_size_extremes();
        test_backpressure();
        test_random_frames();
        wait_drained();
        $display("run covered %0d working input beats, %0d edge pixels checked,",
                 work_beats, edges_checked);
        $display("%0d closed frames and %0d register writes", frames_closed, reg_writes);
        if (fail_count == 0) begin
            $display("sobel_compass_edge_filter_top regression: pass");
        end else begin
            $display("sobel_compass_edge_filter_top regression: fail");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+sv
sv/sce_pkg.sv
sv/sobel_compass_edge_filter_top.sv
sim/testbench.sv
